@@ rtl/core/radix_tree_key_value_map_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the radix tree key/value map
// Concurrent checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RADIX_TREE_KEY_VALUE_MAP_ASSERT_SVH
`define RADIX_TREE_KEY_VALUE_MAP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RTKV_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define RTKV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RTKV_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define RTKV_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/core/rtkv_pkg.sv @@
// ----------------------------------------------------------------------------
// rtkv_pkg
// Shared widths, request codes and types of the radix tree key/value map.
// ----------------------------------------------------------------------------
`default_nettype none

package rtkv_pkg;

  localparam int TYPE_W = 2;
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;

  localparam int NODE_POOL_DEF = 64;
  localparam int LEAF_POOL_DEF = 64;

  // key byte positions, most significant first
  localparam int SHIFT_TOP = 24;
  localparam int SHIFT_MID = 16;
  localparam int SHIFT_LOW = 8;

  localparam int FANOUT_W = 8;
  localparam int FANOUT   = 1 << FANOUT_W;

  localparam logic [TYPE_W-1:0] REQ_MAP    = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd2;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] answer;
    logic             status;
  } rtkv_res_t;

endpackage

`default_nettype wire

@@ rtl/core/radix_tree_key_value_map.sv @@
// ----------------------------------------------------------------------------
// radix_tree_key_value_map
// 32-bit key to 32-bit value map over a four-level, 256-way radix tree.
// ----------------------------------------------------------------------------
//
//   channel   dir  fields (low bit up)                    transaction
//   s_*       in   tuser: req_type | tdata: key, value    one request
//   m_*       out  tuser: status   | tdata: answer        one result
//
// Lookup: a request walks the link memory one dependent read per level,
// stopping at the first null link, then reads the leaf word if a leaf exists.
// A map or delete on an existing path walks the same links, checks both pools
// and writes the leaf word; every node or leaf it must allocate adds a
// clearing sweep, a link write and one more allocation step.
// Reset: the root node is cleared by a sweep; s_tready stays low.
// Stalls: the result sits in an output register, so the next request is taken
// while it waits; a finished request holds until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "radix_tree_key_value_map_assert.svh"

module radix_tree_key_value_map #(
  parameter int NODE_POOL = rtkv_pkg::NODE_POOL_DEF,
  parameter int LEAF_POOL = rtkv_pkg::LEAF_POOL_DEF
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      s_tvalid,
  output logic                                           s_tready,
  // key [31:0], value [63:32]
  input  wire logic [rtkv_pkg::KEY_W+rtkv_pkg::VAL_W-1:0] s_tdata,
  // req_type [1:0]
  input  wire logic [rtkv_pkg::TYPE_W-1:0]               s_tuser,
  output logic                                           m_tvalid,
  input  wire logic                                      m_tready,
  // answer [31:0]
  output logic      [rtkv_pkg::VAL_W-1:0]                m_tdata,
  // status [0]
  output logic                                           m_tuser
);

  import rtkv_pkg::*;

  localparam int MAXPOOL = (NODE_POOL > LEAF_POOL) ? NODE_POOL : LEAF_POOL;
  localparam int LW      = $clog2(MAXPOOL + 1);

  rtkv_res_t     res;
  logic          take;
  logic [LW-1:0] nodes_used;
  logic [LW-1:0] leaves_used;

  // result moves to the output register once it is empty or being drained
  assign take = res.done && (!m_tvalid || m_tready);

  rtkv_ctrl #(
    .NODE_POOL (NODE_POOL),
    .LEAF_POOL (LEAF_POOL),
    .LW        (LW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_type     (s_tuser),
    .in_key      (s_tdata[KEY_W-1:0]),
    .in_value    (s_tdata[KEY_W +: VAL_W]),
    .take        (take),
    .res         (res),
    .nodes_used  (nodes_used),
    .leaves_used (leaves_used)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= res.answer;
      m_tuser <= res.status;
    end
  end

  // one request in flight: acceptance drops ready
  `RTKV_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready, "request accepted while busy")
  // a pool error never carries an answer
  `RTKV_ASSERT_IMPL(a_err_zero_answer, clk, rst, m_tvalid && m_tuser, m_tdata == '0, "error result with non-zero answer")
  // allocation never runs past either pool
  `RTKV_ASSERT_IMPL(a_pool_bounds, clk, rst, 1'b1, (nodes_used <= NODE_POOL) && (leaves_used <= LEAF_POOL), "pool counter beyond pool size")
  // results are only loaded from a finished request
  `RTKV_ASSERT_IMPL(a_take_when_done, clk, rst, take, res.done && !s_tready, "result taken without a finished request")

endmodule

`default_nettype wire

@@ rtl/core/rtkv_addcmp.sv @@
// ----------------------------------------------------------------------------
// rtkv_addcmp
// Shared add and limit compare: pool checks and allocation counts.
// ----------------------------------------------------------------------------
`default_nettype none

module rtkv_addcmp #(
  parameter int CW = 8
) (
  input  wire logic [CW-1:0] a,
  input  wire logic [CW-1:0] b,
  input  wire logic [CW-1:0] limit,
  output logic      [CW-1:0] sum,
  output logic               over
);

  assign sum  = a + b;
  assign over = (sum > limit);

endmodule

`default_nettype wire

@@ rtl/core/rtkv_ctrl.sv @@
// ----------------------------------------------------------------------------
// rtkv_ctrl
// Sequencer with link and leaf memories: path walk, pool check, allocation.
// ----------------------------------------------------------------------------
`default_nettype none

module rtkv_ctrl #(
  parameter int NODE_POOL = rtkv_pkg::NODE_POOL_DEF,
  parameter int LEAF_POOL = rtkv_pkg::LEAF_POOL_DEF,
  parameter int LW        = $clog2(((NODE_POOL > LEAF_POOL) ? NODE_POOL : LEAF_POOL) + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rtkv_pkg::TYPE_W-1:0]   in_type,
  input  wire logic [rtkv_pkg::KEY_W-1:0]    in_key,
  input  wire logic [rtkv_pkg::VAL_W-1:0]    in_value,
  input  wire logic                          take,
  output rtkv_pkg::rtkv_res_t                res,
  output logic      [LW-1:0]                 nodes_used,
  output logic      [LW-1:0]                 leaves_used
);

  import rtkv_pkg::*;

  localparam int MAXPOOL    = (NODE_POOL > LEAF_POOL) ? NODE_POOL : LEAF_POOL;
  localparam int CW         = $clog2(MAXPOOL + 3);
  localparam int LINK_DEPTH = (NODE_POOL + 1) * FANOUT;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int LEAF_DEPTH = LEAF_POOL * FANOUT;
  localparam int LEAF_AW    = $clog2(LEAF_DEPTH);

  typedef enum logic [13:0] {
    S_CLR_ROOT = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_RD1      = 14'b00000000000100,
    S_RD2      = 14'b00000000001000,
    S_RD3      = 14'b00000000010000,
    S_DECIDE   = 14'b00000000100000,
    S_CHKL     = 14'b00000001000000,
    S_LEAFRD   = 14'b00000010000000,
    S_ALLOC    = 14'b00000100000000,
    S_CLR_NODE = 14'b00001000000000,
    S_CLR_LEAF = 14'b00010000000000,
    S_LINK     = 14'b00100000000000,
    S_WRLEAF   = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } state_t;

  typedef enum logic [2:0] {
    TGT_L1   = 3'b001,
    TGT_L2   = 3'b010,
    TGT_LEAF = 3'b100
  } tgt_t;

  state_t state, state_next;
  tgt_t   tgt;

  logic [TYPE_W-1:0]   rtype;
  logic [KEY_W-1:0]    key;
  logic [VAL_W-1:0]    value;
  logic [LW-1:0]       l1, l2, lf, new_id;
  logic [FANOUT_W-1:0] cnt;
  logic [VAL_W-1:0]    answer;
  logic                status;

  logic [FANOUT_W-1:0] b1, b2, b3, b4;
  logic                l1_nul, l2_nul, lf_nul;
  logic [1:0]          need_n;

  // memories
  logic [LW-1:0]    link_mem [LINK_DEPTH];
  logic [VAL_W-1:0] leaf_mem [LEAF_DEPTH];

  logic               lk_we;
  logic [LINK_AW-1:0] lk_waddr, lk_raddr;
  logic [LW-1:0]      lk_wdata, lk_rdata;
  logic               lv_we;
  logic [LEAF_AW-1:0] lv_waddr, lv_raddr;
  logic [VAL_W-1:0]   lv_wdata, lv_rdata;

  // shared unit
  logic [CW-1:0] ua, ub, ul, usum;
  logic          uover;

  function automatic logic [LINK_AW-1:0] link_addr(input logic [LW-1:0] n,
                                                   input logic [FANOUT_W-1:0] s);
    logic [LW+FANOUT_W-1:0] w;
    w = {n, s};
    return w[LINK_AW-1:0];
  endfunction

  function automatic logic [LEAF_AW-1:0] leaf_addr(input logic [LW-1:0] n,
                                                   input logic [FANOUT_W-1:0] s);
    logic [LW-1:0]          idx;
    logic [LW+FANOUT_W-1:0] w;
    idx = n - LW'(1);
    w   = {idx, s};
    return w[LEAF_AW-1:0];
  endfunction

  assign b1 = key[SHIFT_TOP +: FANOUT_W];
  assign b2 = key[SHIFT_MID +: FANOUT_W];
  assign b3 = key[SHIFT_LOW +: FANOUT_W];
  assign b4 = key[0 +: FANOUT_W];

  assign l1_nul = (l1 == '0);
  assign l2_nul = (l2 == '0);
  assign lf_nul = (lf == '0);
  assign need_n = {l1_nul & l2_nul, l1_nul ^ l2_nul};

  rtkv_addcmp #(.CW(CW)) u_addcmp (
    .a     (ua),
    .b     (ub),
    .limit (ul),
    .sum   (usum),
    .over  (uover)
  );

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
    lk_rdata <= link_mem[lk_raddr];
  end

  always_ff @(posedge clk) begin
    if (lv_we) begin
      leaf_mem[lv_waddr] <= lv_wdata;
    end
    lv_rdata <= leaf_mem[lv_raddr];
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    lk_we      = 1'b0;
    lk_waddr   = '0;
    lk_wdata   = '0;
    lk_raddr   = '0;
    lv_we      = 1'b0;
    lv_waddr   = '0;
    lv_wdata   = '0;
    lv_raddr   = '0;
    ua         = CW'(nodes_used);
    ub         = '0;
    ul         = CW'(NODE_POOL);
    case (state)
      S_CLR_ROOT: begin
        lk_we    = 1'b1;
        lk_waddr = link_addr('0, cnt);
        if (cnt == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        lk_raddr = link_addr('0, in_key[SHIFT_TOP +: FANOUT_W]);
        if (in_valid) begin
          if (in_type inside {REQ_MAP, REQ_LOOKUP, REQ_DELETE}) begin
            state_next = S_RD1;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_RD1: begin
        lk_raddr = link_addr(lk_rdata, b2);
        state_next = (lk_rdata == '0) ? S_DECIDE : S_RD2;
      end
      S_RD2: begin
        lk_raddr = link_addr(lk_rdata, b3);
        state_next = (lk_rdata == '0) ? S_DECIDE : S_RD3;
      end
      S_RD3: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        lv_raddr = leaf_addr(lf, b4);
        ub       = CW'(need_n);
        if (rtype == REQ_LOOKUP) begin
          state_next = lf_nul ? S_DONE : S_LEAFRD;
        end else begin
          state_next = uover ? S_DONE : S_CHKL;
        end
      end
      S_CHKL: begin
        ua = CW'(leaves_used);
        ub = CW'(lf_nul);
        ul = CW'(LEAF_POOL);
        state_next = uover ? S_DONE : S_ALLOC;
      end
      S_LEAFRD: begin
        state_next = S_DONE;
      end
      S_ALLOC: begin
        ub = CW'(1);
        if (l1_nul || l2_nul) begin
          state_next = S_CLR_NODE;
        end else if (lf_nul) begin
          ua = CW'(leaves_used);
          ul = CW'(LEAF_POOL);
          state_next = S_CLR_LEAF;
        end else begin
          state_next = S_WRLEAF;
        end
      end
      S_CLR_NODE: begin
        lk_we    = 1'b1;
        lk_waddr = link_addr(new_id, cnt);
        if (cnt == '1) begin
          state_next = S_LINK;
        end
      end
      S_CLR_LEAF: begin
        lv_we    = 1'b1;
        lv_waddr = leaf_addr(new_id, cnt);
        if (cnt == '1) begin
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        lk_we    = 1'b1;
        lk_wdata = new_id;
        case (tgt)
          TGT_L1:   lk_waddr = link_addr('0, b1);
          TGT_L2:   lk_waddr = link_addr(l1, b2);
          TGT_LEAF: lk_waddr = link_addr(l2, b3);
          default:  lk_waddr = link_addr(l2, b3);
        endcase
        state_next = S_ALLOC;
      end
      S_WRLEAF: begin
        lv_we    = 1'b1;
        lv_waddr = leaf_addr(lf, b4);
        lv_wdata = (rtype == REQ_DELETE) ? '0 : value;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR_ROOT;
      cnt         <= '0;
      nodes_used  <= '0;
      leaves_used <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CLR_ROOT, S_CLR_NODE, S_CLR_LEAF: begin
          cnt <= cnt + 1'b1;
        end
        S_ALLOC: begin
          cnt <= '0;
          if (l1_nul || l2_nul) begin
            nodes_used <= usum[LW-1:0];
          end else if (lf_nul) begin
            leaves_used <= usum[LW-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        rtype  <= in_type;
        key    <= in_key;
        value  <= in_value;
        answer <= '0;
        status <= 1'b0;
      end
      S_RD1: begin
        l1 <= lk_rdata;
        l2 <= '0;
        lf <= '0;
      end
      S_RD2: begin
        l2 <= lk_rdata;
      end
      S_RD3: begin
        lf <= lk_rdata;
      end
      S_DECIDE, S_CHKL: begin
        if (rtype != REQ_LOOKUP && uover) begin
          status <= 1'b1;
        end
      end
      S_LEAFRD: begin
        answer <= lv_rdata;
      end
      S_ALLOC: begin
        new_id <= usum[LW-1:0];
        if (l1_nul) begin
          tgt <= TGT_L1;
        end else if (l2_nul) begin
          tgt <= TGT_L2;
        end else begin
          tgt <= TGT_LEAF;
        end
      end
      S_LINK: begin
        case (tgt)
          TGT_L1:   l1 <= new_id;
          TGT_L2:   l2 <= new_id;
          TGT_LEAF: lf <= new_id;
          default:  lf <= new_id;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign res.done   = (state == S_DONE);
  assign res.answer = answer;
  assign res.status = status;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: radix tree key/value map testbench
// Streams map, lookup and delete requests into the map. A scoreboard keeps
// its own copy of the tree, the node pool and the leaf pool, predicts each
// result and checks the answer and status of every result transaction in
// order. Both stream sides idle at random. The key mix keeps most traffic
// on known paths, so that both pools run dry during the run.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtkv_pkg::*;

  localparam int NODE_POOL = NODE_POOL_DEF;
  localparam int LEAF_POOL = LEAF_POOL_DEF;

  // request code not listed in the package: the block must ignore it
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

  // status codes on m_tuser
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  localparam int RANDOM_ITEMS = 1880;
  localparam int MAX_IDLE     = 3;
  localparam int TAIL_CYCLES  = 50;
  // the limit covers the slowest correct run (reset sweep, every allocation
  // sweep, full idling on both sides) several times over
  localparam int CYCLE_LIMIT  = 500000;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [VAL_W-1:0] answer;
    logic             status;
  } map_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the tree plus the queue of results still owed
  // --------------------------------------------------------------------------
  class map_scoreboard;
    // links of the root (node 0) and of nodes 1..NODE_POOL
    bit [6:0]        link_mem [0:(NODE_POOL+1)*FANOUT-1];
    // answer words of leaves 1..LEAF_POOL, leaf n at (n-1)*FANOUT
    bit [VAL_W-1:0]  word_mem [0:LEAF_POOL*FANOUT-1];
    int unsigned     nodes_taken;
    int unsigned     leaves_taken;
    map_result_t     owed [$];
    int unsigned     faults;

    function int unsigned grab_node();
      nodes_taken++;
      for (int i = 0; i < FANOUT; i++) link_mem[nodes_taken*FANOUT+i] = '0;
      return nodes_taken;
    endfunction

    function void flag(string msg);
      faults++;
      if (faults <= REPORT_MAX) $display("ERROR: %s", msg);
    endfunction

    // predict the result of one accepted request transaction
    function void note_request(logic [TYPE_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] val);
      logic [7:0]  b_top, b_mid, b_low, b_word;
      int unsigned lvl1, lvl2, leaf, need_nodes, need_leaf;
      map_result_t res;
      b_top  = 8'(key >> SHIFT_TOP);
      b_mid  = 8'(key >> SHIFT_MID);
      b_low  = 8'(key >> SHIFT_LOW);
      b_word = key[7:0];
      res.answer = '0;
      res.status = ST_OK;
      if (kind != REQ_UNUSED) begin
        // walk as far as the links go; a null link ends the path
        lvl1 = link_mem[b_top];
        lvl2 = (lvl1 != 0) ? link_mem[lvl1*FANOUT+b_mid] : 0;
        leaf = (lvl2 != 0) ? link_mem[lvl2*FANOUT+b_low] : 0;
        if (leaf > LEAF_POOL) leaf = 0;
        if (kind == REQ_LOOKUP) begin
          if (leaf != 0) res.answer = word_mem[(leaf-1)*FANOUT+b_word];
        end else begin
          need_nodes = ((lvl1 == 0) ? 1 : 0) + ((lvl2 == 0) ? 1 : 0);
          need_leaf  = (leaf == 0) ? 1 : 0;
          // all or nothing: a short pool leaves the tree untouched
          if (nodes_taken + need_nodes > NODE_POOL ||
              leaves_taken + need_leaf > LEAF_POOL) begin
            res.status = ST_FULL;
          end else begin
            if (lvl1 == 0) begin
              lvl1 = grab_node();
              link_mem[b_top] = 7'(lvl1);
            end
            if (lvl2 == 0) begin
              lvl2 = grab_node();
              link_mem[lvl1*FANOUT+b_mid] = 7'(lvl2);
            end
            if (leaf == 0) begin
              leaves_taken++;
              leaf = leaves_taken;
              for (int i = 0; i < FANOUT; i++) word_mem[(leaf-1)*FANOUT+i] = '0;
              link_mem[lvl2*FANOUT+b_low] = 7'(leaf);
            end
            word_mem[(leaf-1)*FANOUT+b_word] = (kind == REQ_DELETE) ? '0 : val;
          end
        end
      end
      owed.push_back(res);
    endfunction

    // compare one accepted result transaction with the oldest prediction
    function void check_result(logic [VAL_W-1:0] answer, logic status);
      map_result_t exp;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected result answer=%h status=%b", answer, status));
      end else begin
        exp = owed.pop_front();
        if (answer !== exp.answer)
          flag($sformatf("answer: expected %h, got %h", exp.answer, answer));
        if (status !== exp.status)
          flag($sformatf("status: expected %b, got %b", exp.status, status));
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void close();
      if (owed.size() != 0) flag($sformatf("%0d results never arrived", owed.size()));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [KEY_W+VAL_W-1:0]   s_tdata;   // key [31:0], value [63:32]
  logic [TYPE_W-1:0]        s_tuser;   // req_type [1:0]
  logic                     m_tvalid;
  logic                     m_tready;
  logic [VAL_W-1:0]         m_tdata;   // answer [31:0]
  logic                     m_tuser;   // status [0]

  map_scoreboard sb = new();

  // when set, neither side idles: back-to-back stretches
  bit              no_idle;
  logic [KEY_W-1:0] known_keys [$];
  int unsigned     cycles = 0;

  radix_tree_key_value_map #(
    .NODE_POOL (NODE_POOL),
    .LEAF_POOL (LEAF_POOL)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor: both channels sampled on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_request(s_tuser, s_tdata[KEY_W-1:0], s_tdata[KEY_W+VAL_W-1:KEY_W]);
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata, m_tuser);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // one request transaction; idle gap first, then hold until accepted
  task automatic send_request(logic [TYPE_W-1:0] kind, logic [KEY_W-1:0] key,
                              logic [VAL_W-1:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, key};
    s_tuser  <= kind;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
    // remember every path that a map or delete may have built
    if (kind == REQ_MAP || kind == REQ_DELETE) known_keys.push_back(key);
  endtask

  // receiver: a stall waits for a result to show, so it lands on the result
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
        m_tready <= 1'b0;
        do @(posedge clk); while (!m_tvalid);
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [TYPE_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  val;
    int                pick;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = REQ_MAP;
    no_idle  = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty tree, extremes, partial paths, delete, unused code
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);  // empty root
    send_request(REQ_MAP,    32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_MAP,    32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_LOOKUP, 32'hFFFF_FF00, 32'h0000_0000);  // fresh leaf word
    send_request(REQ_LOOKUP, 32'hFFFF_00FF, 32'h0000_0000);  // no leaf yet
    send_request(REQ_LOOKUP, 32'hFF00_FFFF, 32'h0000_0000);  // no level-two node
    send_request(REQ_MAP,    32'hFFFF_FFFF, 32'h0000_0000);  // overwrite with zero
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_MAP,    32'hFFFF_FFFF, 32'h5A5A_5A5A);
    send_request(REQ_DELETE, 32'hFFFF_FFFF, 32'h1234_5678);
    send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_DELETE, 32'h1234_5678, 32'hFFFF_FFFF);  // delete allocates
    send_request(REQ_LOOKUP, 32'h1234_5678, 32'h0000_0000);
    send_request(REQ_UNUSED, 32'h8765_4321, 32'hDEAD_BEEF);  // ignored
    send_request(REQ_LOOKUP, 32'h8765_4321, 32'h0000_0000);
    send_request(REQ_UNUSED, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_MAP,    32'h8080_8080, 32'h8000_0001);
    send_request(REQ_MAP,    32'h7F7F_7F7F, 32'h7FFF_FFFE);
    send_request(REQ_LOOKUP, 32'h8080_8080, 32'h0000_0000);
    send_request(REQ_LOOKUP, 32'h7F7F_7F7F, 32'h0000_0000);

    // random: mostly keys near known paths, some fresh keys that drain the
    // node pool, and later pool-exhausted maps and deletes
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 8)       kind = REQ_MAP;
      else if (pick < 16) kind = REQ_LOOKUP;
      else if (pick < 19) kind = REQ_DELETE;
      else                kind = REQ_UNUSED;

      key = $urandom;
      if (known_keys.size() != 0 && $urandom_range(0, 9) >= 2) begin
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
        case ($urandom_range(0, 3))
          0: ;                                          // same word
          1: key[7:0]   = 8'($urandom);                 // same leaf
          2: key[15:0]  = 16'($urandom);                // new leaf, same node
          default: key[23:0] = 24'($urandom);           // new level-two node
        endcase
      end

      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = '1;
        default: val = $urandom;
      endcase
      send_request(kind, key, val);
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.close();
    if (sb.faults == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.faults);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
